/* rtl/core/lruot_pkg.sv */
// Shared definitions for the LRU order table: operation codes and default sizes.
// Used by lruot_update and lru_order_table; depends on nothing else.
package lruot_pkg;

  localparam int unsigned OpBits            = 2;
  localparam int unsigned LineAddrBitsDflt  = 6;
  localparam int unsigned WayBitsDflt       = 2;

  typedef enum logic [OpBits-1:0] {
    OP_QUERY   = 2'd0,
    OP_INIT    = 2'd1,
    OP_USED    = 2'd2,
    OP_INVALID = 2'd3
  } op_e;

endpackage

/* rtl/core/lruot_store.sv */
// Order list memory: one write port, one read port with a registered read.
// Stand-alone; no package needed.
module lruot_store #(
  parameter int unsigned AddrBits = 6,
  parameter int unsigned DataBits = 8
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AddrBits-1:0] rd_addr_i,
  output logic [DataBits-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrBits-1:0] wr_addr_i,
  input  logic [DataBits-1:0] wr_data_i
);

  logic [DataBits-1:0] mem [2**AddrBits];
  logic [DataBits-1:0] rd_data_q;

  // A read and a write to the same entry in one cycle return the old contents.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/lruot_update.sv */
// Combinational rewrite of one order list for a given operation.
// Depends on lruot_pkg for the operation codes.
module lruot_update #(
  parameter int unsigned WayBits = 2
) (
  input  lruot_pkg::op_e                   op_i,
  input  logic [WayBits-1:0]               way_i,
  input  logic [(2**WayBits)*WayBits-1:0]  old_list_i,
  output logic [(2**WayBits)*WayBits-1:0]  new_list_o,
  output logic                             wr_en_o
);

  import lruot_pkg::*;

  localparam int unsigned Ways     = 2**WayBits;
  localparam int unsigned ListBits = Ways * WayBits;

  logic [Ways-1:0]     hit;
  logic [ListBits-1:0] init_list;
  logic [ListBits-1:0] up_list;
  logic [ListBits-1:0] down_list;

  // Slot s holds way s after init.
  always_comb begin
    for (int s = 0; s < Ways; s++) begin
      init_list[s*WayBits +: WayBits] = WayBits'(s);
      hit[s] = (old_list_i[s*WayBits +: WayBits] == way_i);
    end
  end

  // Mark used: slots from the way's old place upwards shift down by one and the
  // way goes on top. A slot moves only if no slot above it, below the top, holds
  // the way.
  always_comb begin
    up_list = old_list_i;
    if (!hit[Ways-1]) begin
      up_list[(Ways-1)*WayBits +: WayBits] = way_i;
      for (int s = 0; s < Ways - 1; s++) begin
        if (!(|(hit >> (s + 1)))) begin
          up_list[s*WayBits +: WayBits] = old_list_i[(s+1)*WayBits +: WayBits];
        end
      end
    end
  end

  // Mark invalid: the mirror image, moving the way to the bottom.
  always_comb begin
    down_list = old_list_i;
    if (!hit[0]) begin
      down_list[WayBits-1:0] = way_i;
      for (int s = 1; s < Ways; s++) begin
        if (!(|(hit & Ways'((1 << s) - 1)))) begin
          down_list[s*WayBits +: WayBits] = old_list_i[(s-1)*WayBits +: WayBits];
        end
      end
    end
  end

  always_comb begin
    case (op_i)
      OP_QUERY:   new_list_o = old_list_i;
      OP_INIT:    new_list_o = init_list;
      OP_USED:    new_list_o = up_list;
      OP_INVALID: new_list_o = down_list;
      default:    new_list_o = old_list_i;
    endcase
  end

  assign wr_en_o = (op_i != OP_QUERY);

endmodule

/* rtl/core/lru_order_table.sv */
// LRU order table top level: update stage, order memory, list update, result register.
// Depends on lruot_pkg, lruot_store and lruot_update.
//
// The table keeps, for every cache set, the full recency order of its ways in
// one memory word: the lowest slot is the least recently used way, the highest
// slot the most recently used. Each accepted word reads the order of its set,
// returns the bottom way as it stood before this word, and rewrites the order
// for init, mark-used or mark-invalid (a query leaves it alone). The table takes
// one word per cycle when the result side keeps up. Accepting a word loads the
// registered read of the order memory and the update stage; the update, the
// write-back and the load of the result register happen as the word leaves the
// update stage. When two consecutive words address the same set and the first
// one rewrites the order, the second one is served from a forwarding register
// holding the first one's new order, because its memory read overlaps the first
// one's write. A stalled result side holds the word in the update stage and drops
// in_ready_o, so nothing is lost. The memory is not cleared at reset: a set must
// be initialised before it is read, and the victim reported for a set that was
// never initialised is meaningless.
module lru_order_table #(
  parameter int unsigned LINE_ADDR_BITS = lruot_pkg::LineAddrBitsDflt,
  parameter int unsigned WAY_BITS       = lruot_pkg::WayBitsDflt
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lruot_pkg::OpBits-1:0] operation_i,
  input  logic [LINE_ADDR_BITS-1:0]    line_i,
  input  logic [WAY_BITS-1:0]          way_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [WAY_BITS-1:0]          victim_way_o
);

  import lruot_pkg::*;

  localparam int unsigned ListBits = (2**WAY_BITS) * WAY_BITS;

  // Update stage: the word whose order is being read this cycle.
  logic                      s1_valid_q, s1_valid_d;
  op_e                       s1_op_q;
  logic [LINE_ADDR_BITS-1:0] s1_line_q;
  logic [WAY_BITS-1:0]       s1_way_q;

  // Forwarding of the previous word's new order to a same-set successor.
  logic                      fwd_hit_q, fwd_hit_d;
  logic [ListBits-1:0]       fwd_data_q;

  // Result register.
  logic                      out_valid_q, out_valid_d;
  logic [WAY_BITS-1:0]       victim_q;

  logic                      in_fire;
  logic                      s1_adv;
  logic [ListBits-1:0]       rd_data;
  logic [ListBits-1:0]       old_list;
  logic [ListBits-1:0]       new_list;
  logic                      upd_wr_en;

  // The update stage moves on when the result register is free or being emptied.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  lruot_store #(
    .AddrBits (LINE_ADDR_BITS),
    .DataBits (ListBits)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (line_i),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv && upd_wr_en),
    .wr_addr_i (s1_line_q),
    .wr_data_i (new_list)
  );

  assign old_list = fwd_hit_q ? fwd_data_q : rd_data;

  lruot_update #(
    .WayBits (WAY_BITS)
  ) u_update (
    .op_i       (s1_op_q),
    .way_i      (s1_way_q),
    .old_list_i (old_list),
    .new_list_o (new_list),
    .wr_en_o    (upd_wr_en)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // A new word only ever enters while the stage is empty or moving on, so the
  // write it may race against is exactly the current stage's write-back.
  assign fwd_hit_d = s1_adv && upd_wr_en && (s1_line_q == line_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      // The flag belongs to the word in the update stage, so it is dropped
      // when that word leaves without a successor taking its place.
      if (in_fire) begin
        fwd_hit_q <= fwd_hit_d;
      end else if (s1_adv) begin
        fwd_hit_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= op_e'(operation_i);
      s1_line_q  <= line_i;
      s1_way_q   <= way_i;
      fwd_data_q <= new_list;
    end
    if (s1_adv) begin
      victim_q <= old_list[WAY_BITS-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign victim_way_o = victim_q;

  // A word leaving the update stage always lands in the result register.
  a_adv_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("update stage advanced without filling the result register");

  // Forwarding is only ever armed for a word that sits in the update stage.
  a_fwd_needs_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forwarding flag set with an empty update stage");

  // A stalled word keeps its set and its forwarding decision.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_line_q) && $stable(fwd_hit_q)))
    else $error("stalled update stage lost its word");

  // A same-set successor entering behind a write-back must use forwarding.
  a_fwd_on_race : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s1_adv && upd_wr_en && (s1_line_q == line_i)) |=> fwd_hit_q)
    else $error("same-set successor missed the forwarded order");

endmodule
